### hw/rtl/lobm_pkg.sv
`timescale 1ns / 1ps
package lobm_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_MATCH  = 2'd2;

  localparam logic [2:0] ST_TRADE     = 3'd0;
  localparam logic [2:0] ST_ADDED     = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_CANCELLED = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_NO_CROSS  = 3'd5;
  localparam logic [2:0] ST_BAD       = 3'd6;

  localparam int          NTW        = 7;
  localparam logic [6:0]  MAX_TRADES = 7'd64;

  typedef struct packed {
    logic [2:0]  status;
    logic [30:0] trade_quantity;
    logic [15:0] trade_price;
    logic [31:0] buyer_id;
    logic [31:0] seller_id;
  } res_t;

  function automatic res_t mk_res(input logic [2:0] code);
    res_t r;
    r = '0;
    r.status = code;
    return r;
  endfunction

endpackage

### hw/rtl/lobm_if.sv
`timescale 1ns / 1ps
interface lobm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic        side;
  logic [31:0] order_id;
  logic [15:0] price;
  logic [30:0] quantity;
  modport source(output valid, opcode, side, order_id, price, quantity, input ready);
  modport sink(input valid, opcode, side, order_id, price, quantity, output ready);
endinterface

interface lobm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [30:0] trade_quantity;
  logic [15:0] trade_price;
  logic [31:0] buyer_id;
  logic [31:0] seller_id;
  logic        last;
  modport source(output valid, status, trade_quantity, trade_price, buyer_id, seller_id, last,
                 input ready);
  modport sink(input valid, status, trade_quantity, trade_price, buyer_id, seller_id, last,
               output ready);
endinterface

### hw/rtl/lobm_outreg.sv
`timescale 1ns / 1ps
module lobm_outreg (
  input logic clk,
  input logic rst_n,
  lobm_out_if.sink   up,
  lobm_out_if.source down
);
  logic        vld_r;
  logic [2:0]  status_r;
  logic [30:0] qty_r;
  logic [15:0] px_r;
  logic [31:0] bid_r;
  logic [31:0] sid_r;
  logic        last_r;

  assign up.ready = !vld_r || down.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up.valid && up.ready) begin
      vld_r <= 1'b1;
    end else if (down.ready) begin
      vld_r <= 1'b0;
    end
    if (up.valid && up.ready) begin
      status_r <= up.status;
      qty_r    <= up.trade_quantity;
      px_r     <= up.trade_price;
      bid_r    <= up.buyer_id;
      sid_r    <= up.seller_id;
      last_r   <= up.last;
    end
  end

  assign down.valid          = vld_r;
  assign down.status         = status_r;
  assign down.trade_quantity = qty_r;
  assign down.trade_price    = px_r;
  assign down.buyer_id       = bid_r;
  assign down.seller_id      = sid_r;
  assign down.last           = last_r;
endmodule

### hw/rtl/lobm_ctrl.sv
`timescale 1ns / 1ps
module lobm_ctrl #(
  parameter int ORDER_SLOTS     = 64,
  parameter int LEVELS_PER_SIDE = 16
) (
  input logic clk,
  input logic rst_n,
  lobm_in_if.sink    in_ch,
  lobm_out_if.source res
);
  import lobm_pkg::*;

  localparam int S  = ORDER_SLOTS;
  localparam int L  = LEVELS_PER_SIDE;
  localparam int TL = 2 * L;
  localparam int SW = $clog2(S);
  localparam int LW = $clog2(TL);
  localparam int PW = (SW > LW) ? SW : LW;
  localparam int CW = PW + 1;

  typedef struct packed {
    logic [31:0]   id;
    logic [30:0]   qty;
    logic [LW-1:0] lvl;
    logic [SW-1:0] nxt;
  } slot_t;

  typedef struct packed {
    logic [15:0]   price;
    logic [SW-1:0] head;
    logic [SW-1:0] tail;
  } lvl_t;

  typedef enum logic [3:0] {
    IDLE, ID_SCAN, LV_SCAN, ADD_WR, ADD_LNK, CAN_LV, CAN_HD, CAN_WALK, CAN_STEP,
    M_BEST, EMIT_MID, M_RB, M_RA, M_CMP, M_UPA, EMIT_LAST
  } st_t;

  // slot and level memories, one write and one registered read each
  slot_t smem [S];
  lvl_t  lmem [TL];
  logic          s_we, l_we;
  logic [SW-1:0] s_waddr, s_raddr;
  logic [LW-1:0] l_waddr, l_raddr;
  slot_t         s_wdata, s_q;
  lvl_t          l_wdata, l_q;

  always_ff @(posedge clk) begin
    if (s_we) smem[s_waddr] <= s_wdata;
    s_q <= smem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (l_we) lmem[l_waddr] <= l_wdata;
    l_q <= lmem[l_raddr];
  end

  st_t st_r, st_nxt;
  logic [S-1:0]  svld_r;
  logic [TL-1:0] lvld_r;
  logic sv_set, sv_clr, lv_set, lv_clr;
  logic [SW-1:0] sv_idx;
  logic [LW-1:0] lv_idx;

  logic [1:0]  op_r, op_nxt;
  logic        side_r, side_nxt;
  logic [31:0] id_r, id_nxt;
  logic [15:0] price_r, price_nxt;
  logic [30:0] qty_r, qty_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pv_r, pv_nxt;
  logic [PW-1:0] pi_r, pi_nxt;
  logic          found_r, found_nxt, free_r, free_nxt;
  logic [SW-1:0] fidx_r, fidx_nxt, freeidx_r, freeidx_nxt;
  slot_t         fq_r, fq_nxt;
  logic          lfound_r, lfound_nxt, lfree_r, lfree_nxt;
  logic [LW-1:0] lidx_r, lidx_nxt, lfreeidx_r, lfreeidx_nxt;
  lvl_t          lq_r, lq_nxt;
  logic [SW-1:0] cur_r, cur_nxt, prev_r, prev_nxt;
  slot_t         pq_r, pq_nxt;
  logic          bv_r, bv_nxt, av_r, av_nxt;
  logic [LW-1:0] bl_r, bl_nxt, al_r, al_nxt;
  lvl_t          blq_r, blq_nxt, alq_r, alq_nxt;
  slot_t         bq_r, bq_nxt, aq_r, aq_nxt;
  res_t          pend_r, pend_nxt;
  logic [NTW-1:0] ntr_r, ntr_nxt;

  always_comb begin
    slot_t         tmp;
    logic [LW-1:0] la;
    logic [30:0]   q;
    logic [30:0]   nb;
    st_nxt = st_r;
    op_nxt = op_r; side_nxt = side_r; id_nxt = id_r; price_nxt = price_r; qty_nxt = qty_r;
    cnt_nxt = cnt_r; pv_nxt = pv_r; pi_nxt = pi_r;
    found_nxt = found_r; free_nxt = free_r; fidx_nxt = fidx_r; freeidx_nxt = freeidx_r;
    fq_nxt = fq_r;
    lfound_nxt = lfound_r; lfree_nxt = lfree_r; lidx_nxt = lidx_r;
    lfreeidx_nxt = lfreeidx_r; lq_nxt = lq_r;
    cur_nxt = cur_r; prev_nxt = prev_r; pq_nxt = pq_r;
    bv_nxt = bv_r; av_nxt = av_r; bl_nxt = bl_r; al_nxt = al_r;
    blq_nxt = blq_r; alq_nxt = alq_r; bq_nxt = bq_r; aq_nxt = aq_r;
    pend_nxt = pend_r; ntr_nxt = ntr_r;
    s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_raddr = '0;
    l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_raddr = '0;
    sv_set = 1'b0; sv_clr = 1'b0; sv_idx = '0;
    lv_set = 1'b0; lv_clr = 1'b0; lv_idx = '0;
    tmp = '0; la = '0; q = '0; nb = '0;
    in_ch.ready = 1'b0;
    res.valid = 1'b0;
    res.last  = 1'b0;
    res.status         = pend_r.status;
    res.trade_quantity = pend_r.trade_quantity;
    res.trade_price    = pend_r.trade_price;
    res.buyer_id       = pend_r.buyer_id;
    res.seller_id      = pend_r.seller_id;

    unique case (st_r)
      IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          op_nxt = in_ch.opcode; side_nxt = in_ch.side; id_nxt = in_ch.order_id;
          price_nxt = in_ch.price; qty_nxt = in_ch.quantity;
          cnt_nxt = '0; pv_nxt = 1'b0;
          found_nxt = 1'b0; free_nxt = 1'b0; lfound_nxt = 1'b0; lfree_nxt = 1'b0;
          bv_nxt = 1'b0; av_nxt = 1'b0; ntr_nxt = '0;
          priority if (in_ch.opcode == OP_ADD || in_ch.opcode == OP_CANCEL) begin
            st_nxt = ID_SCAN;
          end else if (in_ch.opcode == OP_MATCH) begin
            st_nxt = M_BEST;
          end else begin
            pend_nxt = mk_res(ST_BAD);
            st_nxt = EMIT_LAST;
          end
        end
      end

      ID_SCAN: begin
        // issue one slot read a cycle, check the word read the cycle before
        if (cnt_r < CW'(S)) begin
          s_raddr = cnt_r[SW-1:0];
          pv_nxt = 1'b1;
          pi_nxt = cnt_r[PW-1:0];
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r) begin
          if (svld_r[pi_r[SW-1:0]]) begin
            if (s_q.id == id_r && !found_r) begin
              found_nxt = 1'b1; fidx_nxt = pi_r[SW-1:0]; fq_nxt = s_q;
            end
          end else if (!free_r) begin
            free_nxt = 1'b1; freeidx_nxt = pi_r[SW-1:0];
          end
        end
        if (cnt_r == CW'(S) && !pv_r) begin
          if (op_r == OP_CANCEL) begin
            if (!found_r) begin
              pend_nxt = mk_res(ST_NOT_FOUND); st_nxt = EMIT_LAST;
            end else begin
              st_nxt = CAN_LV;
            end
          end else if (qty_r == '0 || found_r) begin
            pend_nxt = mk_res(ST_BAD); st_nxt = EMIT_LAST;
          end else if (!free_r) begin
            pend_nxt = mk_res(ST_FULL); st_nxt = EMIT_LAST;
          end else begin
            cnt_nxt = '0; st_nxt = LV_SCAN;
          end
        end
      end

      LV_SCAN: begin
        if (cnt_r < CW'(L)) begin
          l_raddr = side_r ? LW'(LW'(L) + cnt_r[LW-1:0]) : cnt_r[LW-1:0];
          pv_nxt = 1'b1;
          pi_nxt = cnt_r[PW-1:0];
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r) begin
          la = side_r ? LW'(LW'(L) + pi_r[LW-1:0]) : pi_r[LW-1:0];
          if (lvld_r[la]) begin
            if (l_q.price == price_r && !lfound_r) begin
              lfound_nxt = 1'b1; lidx_nxt = la; lq_nxt = l_q;
            end
          end else if (!lfree_r) begin
            lfree_nxt = 1'b1; lfreeidx_nxt = la;
          end
        end
        if (cnt_r == CW'(L) && !pv_r) begin
          if (!lfound_r && !lfree_r) begin
            pend_nxt = mk_res(ST_FULL); st_nxt = EMIT_LAST;
          end else begin
            st_nxt = ADD_WR;
          end
        end
      end

      ADD_WR: begin
        s_we = 1'b1;
        s_waddr = freeidx_r;
        s_wdata.id = id_r;
        s_wdata.qty = qty_r;
        s_wdata.lvl = lfound_r ? lidx_r : lfreeidx_r;
        s_wdata.nxt = freeidx_r;
        sv_set = 1'b1; sv_idx = freeidx_r;
        l_we = 1'b1;
        if (lfound_r) begin
          // append at tail: relink the old tail next cycle
          l_waddr = lidx_r;
          l_wdata = '{price: lq_r.price, head: lq_r.head, tail: freeidx_r};
          s_raddr = lq_r.tail;
          st_nxt = ADD_LNK;
        end else begin
          l_waddr = lfreeidx_r;
          l_wdata = '{price: price_r, head: freeidx_r, tail: freeidx_r};
          lv_set = 1'b1; lv_idx = lfreeidx_r;
          pend_nxt = mk_res(ST_ADDED); st_nxt = EMIT_LAST;
        end
      end

      ADD_LNK: begin
        tmp = s_q;
        tmp.nxt = freeidx_r;
        s_we = 1'b1; s_waddr = lq_r.tail; s_wdata = tmp;
        pend_nxt = mk_res(ST_ADDED); st_nxt = EMIT_LAST;
      end

      CAN_LV: begin
        l_raddr = fq_r.lvl;
        st_nxt = CAN_HD;
      end

      CAN_HD: begin
        lq_nxt = l_q;
        if (l_q.head == fidx_r) begin
          sv_clr = 1'b1; sv_idx = fidx_r;
          if (l_q.tail == fidx_r) begin
            lv_clr = 1'b1; lv_idx = fq_r.lvl;
          end else begin
            l_we = 1'b1; l_waddr = fq_r.lvl;
            l_wdata = '{price: l_q.price, head: fq_r.nxt, tail: l_q.tail};
          end
          pend_nxt = mk_res(ST_CANCELLED); st_nxt = EMIT_LAST;
        end else begin
          cur_nxt = l_q.head; prev_nxt = l_q.head;
          st_nxt = CAN_WALK;
        end
      end

      CAN_WALK: begin
        if (cur_r == fidx_r) begin
          sv_clr = 1'b1; sv_idx = fidx_r;
          if (lq_r.tail == fidx_r) begin
            l_we = 1'b1; l_waddr = fq_r.lvl;
            l_wdata = '{price: lq_r.price, head: lq_r.head, tail: prev_r};
          end else begin
            tmp = pq_r;
            tmp.nxt = fq_r.nxt;
            s_we = 1'b1; s_waddr = prev_r; s_wdata = tmp;
          end
          pend_nxt = mk_res(ST_CANCELLED); st_nxt = EMIT_LAST;
        end else if (cur_r == lq_r.tail) begin
          sv_clr = 1'b1; sv_idx = fidx_r;
          pend_nxt = mk_res(ST_CANCELLED); st_nxt = EMIT_LAST;
        end else begin
          s_raddr = cur_r;
          st_nxt = CAN_STEP;
        end
      end

      CAN_STEP: begin
        pq_nxt = s_q;
        prev_nxt = cur_r;
        cur_nxt = s_q.nxt;
        st_nxt = CAN_WALK;
      end

      M_BEST: begin
        // walk all levels; first strictly better price wins
        if (cnt_r < CW'(TL)) begin
          l_raddr = cnt_r[LW-1:0];
          pv_nxt = 1'b1;
          pi_nxt = cnt_r[PW-1:0];
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r && lvld_r[pi_r[LW-1:0]]) begin
          if (pi_r < PW'(L)) begin
            if (!bv_r || l_q.price > blq_r.price) begin
              bv_nxt = 1'b1; bl_nxt = pi_r[LW-1:0]; blq_nxt = l_q;
            end
          end else if (!av_r || l_q.price < alq_r.price) begin
            av_nxt = 1'b1; al_nxt = pi_r[LW-1:0]; alq_nxt = l_q;
          end
        end
        if (cnt_r == CW'(TL) && !pv_r) begin
          if (!(bv_r && av_r && blq_r.price >= alq_r.price)) begin
            if (ntr_r == '0) pend_nxt = mk_res(ST_NO_CROSS);
            st_nxt = EMIT_LAST;
          end else if (ntr_r != '0) begin
            st_nxt = EMIT_MID;
          end else begin
            st_nxt = M_RB;
          end
        end
      end

      EMIT_MID: begin
        res.valid = 1'b1;
        if (res.ready) st_nxt = M_RB;
      end

      M_RB: begin
        s_raddr = blq_r.head;
        st_nxt = M_RA;
      end

      M_RA: begin
        bq_nxt = s_q;
        s_raddr = alq_r.head;
        st_nxt = M_CMP;
      end

      M_CMP: begin
        q = (bq_r.qty < s_q.qty) ? bq_r.qty : s_q.qty;
        pend_nxt.status = ST_TRADE;
        pend_nxt.trade_quantity = q;
        pend_nxt.trade_price = (bq_r.id < s_q.id) ? blq_r.price : alq_r.price;
        pend_nxt.buyer_id = bq_r.id;
        pend_nxt.seller_id = s_q.id;
        aq_nxt = s_q;
        aq_nxt.qty = s_q.qty - q;
        nb = bq_r.qty - q;
        if (nb != '0) begin
          tmp = bq_r;
          tmp.qty = nb;
          s_we = 1'b1; s_waddr = blq_r.head; s_wdata = tmp;
        end else begin
          sv_clr = 1'b1; sv_idx = blq_r.head;
          if (blq_r.head == blq_r.tail) begin
            lv_clr = 1'b1; lv_idx = bl_r;
          end else begin
            l_we = 1'b1; l_waddr = bl_r;
            l_wdata = '{price: blq_r.price, head: bq_r.nxt, tail: blq_r.tail};
          end
        end
        ntr_nxt = ntr_r + 1'b1;
        st_nxt = M_UPA;
      end

      M_UPA: begin
        if (aq_r.qty != '0) begin
          s_we = 1'b1; s_waddr = alq_r.head; s_wdata = aq_r;
        end else begin
          sv_clr = 1'b1; sv_idx = alq_r.head;
          if (alq_r.head == alq_r.tail) begin
            lv_clr = 1'b1; lv_idx = al_r;
          end else begin
            l_we = 1'b1; l_waddr = al_r;
            l_wdata = '{price: alq_r.price, head: aq_r.nxt, tail: alq_r.tail};
          end
        end
        if (ntr_r == MAX_TRADES) begin
          st_nxt = EMIT_LAST;
        end else begin
          cnt_nxt = '0; pv_nxt = 1'b0; bv_nxt = 1'b0; av_nxt = 1'b0;
          st_nxt = M_BEST;
        end
      end

      EMIT_LAST: begin
        res.valid = 1'b1;
        res.last = 1'b1;
        if (res.ready) st_nxt = IDLE;
      end

      default: st_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= IDLE;
      svld_r <= '0;
      lvld_r <= '0;
      pv_r   <= 1'b0;
      ntr_r  <= '0;
    end else begin
      st_r  <= st_nxt;
      pv_r  <= pv_nxt;
      ntr_r <= ntr_nxt;
      if (sv_set) svld_r[sv_idx] <= 1'b1;
      if (sv_clr) svld_r[sv_idx] <= 1'b0;
      if (lv_set) lvld_r[lv_idx] <= 1'b1;
      if (lv_clr) lvld_r[lv_idx] <= 1'b0;
    end
    op_r <= op_nxt; side_r <= side_nxt; id_r <= id_nxt; price_r <= price_nxt; qty_r <= qty_nxt;
    cnt_r <= cnt_nxt; pi_r <= pi_nxt;
    found_r <= found_nxt; free_r <= free_nxt; fidx_r <= fidx_nxt; freeidx_r <= freeidx_nxt;
    fq_r <= fq_nxt;
    lfound_r <= lfound_nxt; lfree_r <= lfree_nxt; lidx_r <= lidx_nxt;
    lfreeidx_r <= lfreeidx_nxt; lq_r <= lq_nxt;
    cur_r <= cur_nxt; prev_r <= prev_nxt; pq_r <= pq_nxt;
    bv_r <= bv_nxt; av_r <= av_nxt; bl_r <= bl_nxt; al_r <= al_nxt;
    blq_r <= blq_nxt; alq_r <= alq_nxt; bq_r <= bq_nxt; aq_r <= aq_nxt;
    pend_r <= pend_nxt;
  end

  a_trade_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ntr_r <= MAX_TRADES)
    else $error("trade count beyond cap");

  a_idle_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !res.valid)
    else $error("result word offered while taking input");

  a_trade_qty: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.status == ST_TRADE) |-> res.trade_quantity != '0)
    else $error("trade word with zero quantity");

endmodule

### hw/rtl/limit_order_book_matcher_top.sv
`timescale 1ns / 1ps
// An add scans every order slot for the id, then the levels of its side for the price.
// A cancel scans the slots for the id, then walks its level's FIFO when the order is not at the head.
// A match scans all levels of both sides for the best bid and ask before each trade.
// One item is in work at a time; the output register takes results one a cycle unless the consumer stalls.
// Reset (rst_n low, synchronous) empties both books; memory contents stay unknown.
module limit_order_book_matcher_top #(
  parameter int ORDER_SLOTS     = 64,
  parameter int LEVELS_PER_SIDE = 16
) (
  input logic clk,
  input logic rst_n,
  lobm_in_if.sink    in_ch,
  lobm_out_if.source out_ch
);
  // result word from the sequencer into the output stage
  lobm_out_if res_ch ();

  // sequencer: owns slot and level memories and all book updates
  lobm_ctrl #(
    .ORDER_SLOTS    (ORDER_SLOTS),
    .LEVELS_PER_SIDE(LEVELS_PER_SIDE)
  ) u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .res  (res_ch)
  );

  // hold each result word until the consumer takes it
  lobm_outreg u_outreg (
    .clk  (clk),
    .rst_n(rst_n),
    .up   (res_ch),
    .down (out_ch)
  );
endmodule

### sim/limit_order_book_matcher_top_tb.sv
`timescale 1ns / 1ps
module limit_order_book_matcher_top_tb;
  import lobm_pkg::*;

  localparam int SLOTS      = 64;
  localparam int LVLS       = 16;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_LEN   = 400;
  localparam int NUM_RANDOM = 100;

  typedef struct packed {
    res_t r;
    logic last;
  } outcome_t;

  // Book shadow: mirrors the resting orders and price levels, and keeps
  // the queue of outcomes the block still owes.
  class book_scoreboard;
    bit [31:0] s_id[SLOTS];
    bit [30:0] s_qty[SLOTS];
    int        s_lvl[SLOTS];
    int        s_nxt[SLOTS];
    bit        s_v[SLOTS];
    bit [15:0] l_px[2*LVLS];
    int        l_hd[2*LVLS];
    int        l_tl[2*LVLS];
    bit        l_v[2*LVLS];
    outcome_t  pending[$];
    int        mismatches;
    int        checked;
    int        trades;

    function int find_slot(bit [31:0] id);
      for (int i = 0; i < SLOTS; i++) if (s_v[i] && s_id[i] == id) return i;
      return -1;
    endfunction

    // highest bid or lowest ask
    function int best_level(bit sd);
      int best;
      int base;
      best = -1;
      base = sd ? LVLS : 0;
      for (int i = base; i < base + LVLS; i++) begin
        if (!l_v[i]) continue;
        if (best < 0 || (!sd && l_px[i] > l_px[best]) || (sd && l_px[i] < l_px[best]))
          best = i;
      end
      return best;
    endfunction

    function void pop_head(int lv);
      int h;
      h = l_hd[lv];
      s_v[h] = 0;
      if (h == l_tl[lv]) l_v[lv] = 0;
      else l_hd[lv] = s_nxt[h];
    endfunction

    function void post(logic [2:0] st);
      outcome_t o;
      o = '0;
      o.r = mk_res(st);
      pending.push_back(o);
    endfunction

    function logic [2:0] rest_order(bit sd, bit [31:0] id, bit [15:0] px, bit [30:0] qty);
      int s, lv, freelv, base;
      s = -1;
      lv = -1;
      freelv = -1;
      base = sd ? LVLS : 0;
      if (qty == 0 || find_slot(id) >= 0) return ST_BAD;
      for (int i = 0; i < SLOTS && s < 0; i++) if (!s_v[i]) s = i;
      for (int i = base; i < base + LVLS; i++) begin
        if (l_v[i]) begin
          if (l_px[i] == px && lv < 0) lv = i;
        end else if (freelv < 0) begin
          freelv = i;
        end
      end
      if (s < 0 || (lv < 0 && freelv < 0)) return ST_FULL;
      s_id[s] = id;
      s_qty[s] = qty;
      s_nxt[s] = s;
      s_v[s] = 1;
      if (lv < 0) begin
        lv = freelv;
        l_px[lv] = px;
        l_hd[lv] = s;
        l_tl[lv] = s;
        l_v[lv] = 1;
      end else begin
        s_nxt[l_tl[lv]] = s;
        l_tl[lv] = s;
      end
      s_lvl[s] = lv;
      return ST_ADDED;
    endfunction

    function logic [2:0] pull_order(bit [31:0] id);
      int s, lv, cur, prv, steps;
      s = find_slot(id);
      if (s < 0) return ST_NOT_FOUND;
      lv = s_lvl[s];
      if (l_hd[lv] == s) begin
        pop_head(lv);
        return ST_CANCELLED;
      end
      prv = l_hd[lv];
      cur = prv;
      steps = 0;
      while (steps < SLOTS && cur != s && cur != l_tl[lv]) begin
        prv = cur;
        cur = s_nxt[cur];
        steps++;
      end
      if (cur == s) begin
        if (l_tl[lv] == s) l_tl[lv] = prv;
        else s_nxt[prv] = s_nxt[s];
      end
      s_v[s] = 0;
      return ST_CANCELLED;
    endfunction

    function void cross_book();
      int n, bl, al, b, a;
      outcome_t o;
      n = 0;
      while (n < MAX_TRADES) begin
        bl = best_level(0);
        al = best_level(1);
        if (bl < 0 || al < 0 || l_px[bl] < l_px[al]) break;
        b = l_hd[bl];
        a = l_hd[al];
        o = '0;
        o.r.status = ST_TRADE;
        o.r.trade_quantity = (s_qty[b] < s_qty[a]) ? s_qty[b] : s_qty[a];
        o.r.trade_price = (s_id[b] < s_id[a]) ? l_px[bl] : l_px[al];
        o.r.buyer_id = s_id[b];
        o.r.seller_id = s_id[a];
        pending.push_back(o);
        n++;
        trades++;
        s_qty[b] -= o.r.trade_quantity;
        s_qty[a] -= o.r.trade_quantity;
        if (s_qty[b] == 0) pop_head(bl);
        if (s_qty[a] == 0) pop_head(al);
      end
      if (n == 0) post(ST_NO_CROSS);
    endfunction

    // note an accepted input word and queue what it must produce
    function void note_input(logic [1:0] op, bit sd, bit [31:0] id, bit [15:0] px,
                             bit [30:0] qty);
      if (op == OP_ADD) post(rest_order(sd, id, px, qty));
      else if (op == OP_CANCEL) post(pull_order(id));
      else if (op == OP_MATCH) cross_book();
      else post(ST_BAD);
      pending[pending.size() - 1].last = 1'b1;
    endfunction

    // compare one accepted output word with the oldest outcome owed
    function void check_result(outcome_t got);
      outcome_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected output word status=%0d", got.r.status);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: want st=%0d q=%0d px=%0d b=%0h s=%0h last=%0b, got st=%0d q=%0d px=%0d b=%0h s=%0h last=%0b",
                   want.r.status, want.r.trade_quantity, want.r.trade_price,
                   want.r.buyer_id, want.r.seller_id, want.last,
                   got.r.status, got.r.trade_quantity, got.r.trade_price,
                   got.r.buyer_id, got.r.seller_id, got.last);
      end
    endfunction

    function bit [31:0] pick_live();
      int live[$];
      for (int i = 0; i < SLOTS; i++) if (s_v[i]) live.push_back(i);
      if (live.size() == 0) return $urandom;
      return s_id[live[$urandom_range(live.size() - 1)]];
    endfunction
  endclass

  logic clk;
  logic rst_n;
  lobm_in_if  in_ch();
  lobm_out_if out_ch();

  limit_order_book_matcher_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  book_scoreboard sb = new;

  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_req;
  int          hold_left;
  int          idle_cycles;
  int          words_sent;
  int          timed_out;
  bit [31:0]   next_id;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Result side: check every accepted word, then pick the next ready.
  // A hold request keeps ready low for a long stretch so the block backs up.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.status, out_ch.trade_quantity, out_ch.trade_price,
                         out_ch.buyer_id, out_ch.seller_id, out_ch.last});
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: count cycles where neither channel moves a word.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
        $display("limit_order_book_matcher_top_tb: done, errors");
        $finish;
      end
    end
  end

  // Offer one word; a random gap may come first. Valid stays high after
  // acceptance so back-to-back words need only one assignment per edge.
  task automatic send_word(logic [1:0] op, bit sd, bit [31:0] id, bit [15:0] px,
                           bit [30:0] qty);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.side     <= sd;
    in_ch.order_id <= id;
    in_ch.price    <= px;
    in_ch.quantity <= qty;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(op, sd, id, px, qty);
    words_sent++;
  endtask

  // Stop offering and wait until every owed word has come back,
  // then let the block settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic add_order(bit sd, bit [15:0] px, bit [30:0] qty);
    next_id += $urandom_range(1, 5);
    send_word(OP_ADD, sd, next_id, px, qty);
  endtask

  // Cancel everything still resting so later traffic starts from an empty book.
  task automatic sweep_book();
    bit [31:0] ids[$];
    for (int i = 0; i < SLOTS; i++) if (sb.s_v[i]) ids.push_back(sb.s_id[i]);
    foreach (ids[i]) send_word(OP_CANCEL, 1'b0, ids[i], '0, '0);
  endtask

  // Fill the levels and slots, bump into both limits, then sweep each side
  // with a huge aggressive order.
  task automatic fill_book();
    for (int i = 0; i < 32; i++)
      add_order(1'b0, 16'(1000 + i % 17), 31'($urandom_range(1, 40)));
    for (int i = 0; i < 33; i++)
      add_order(1'b1, 16'(3000 + i % 16), 31'($urandom_range(1, 40)));
    send_word(OP_MATCH, 1'b0, '0, '0, '0);
    add_order(1'b1, 16'd0, 31'h7FFF_FFFF);
    send_word(OP_CANCEL, 1'b0, sb.pick_live(), '0, '0);
    add_order(1'b1, 16'd0, 31'h7FFF_FFFF);
    send_word(OP_MATCH, 1'b0, '0, '0, '0);
    add_order(1'b0, 16'hFFFF, 31'h7FFF_FFFF);
    send_word(OP_MATCH, 1'b0, '0, '0, '0);
    sweep_book();
  endtask

  // One random burst: mostly well-formed add runs ending in a match,
  // plus cancels, lone matches and raw noise.
  task automatic random_burst(ref int budget);
    int        kind, n;
    bit        sd;
    bit [30:0] qty;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      n = $urandom_range(2, 8);
      for (int i = 0; i < n; i++) begin
        sd = 1'($urandom_range(1));
        qty = ($urandom_range(15) == 0) ? 31'h7FFF_FFFF :
              ($urandom_range(20) == 0) ? 31'd0 : 31'($urandom_range(1, 60));
        if ($urandom_range(7) == 0)
          send_word(OP_ADD, sd, sb.pick_live(), 16'(100 + $urandom_range(0, 20)), qty);
        else
          add_order(sd, sd ? 16'(106 + $urandom_range(0, 12)) : 16'(100 + $urandom_range(0, 12)),
                    qty);
      end
      send_word(OP_MATCH, 1'b0, '0, '0, '0);
      budget += n + 1;
    end else if (kind <= 7) begin
      send_word(OP_CANCEL, 1'($urandom_range(1)),
                ($urandom_range(3) == 0) ? 32'($urandom) : sb.pick_live(), '0, '0);
      budget++;
    end else if (kind == 8) begin
      send_word(2'($urandom_range(0, 3)), 1'($urandom_range(1)), $urandom,
                16'($urandom_range(0, 65535)), 31'($urandom));
      budget++;
    end else begin
      send_word(OP_MATCH, 1'b0, '0, '0, '0);
      budget++;
    end
    // keep the book from clogging with stale far-off orders
    if ($urandom_range(24) == 0) sweep_book();
  endtask

  initial begin
    int random_done;
    int fails;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.opcode   = OP_ADD;
    in_ch.side     = 1'b0;
    in_ch.order_id = '0;
    in_ch.price    = '0;
    in_ch.quantity = '0;
    out_ch.ready   = 1'b0;
    hold_req       = 1'b0;
    hold_left      = 0;
    idle_cycles    = 0;
    words_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    next_id        = 32'd1000;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty match, zero quantity, duplicate id, a two-trade cross
    // priced by the lower order id, cancel hit and miss, unused opcode.
    send_word(OP_MATCH, 1'b0, '0, '0, '0);
    send_word(OP_ADD, 1'b0, 32'd5, 16'd100, 31'd0);
    send_word(OP_ADD, 1'b0, 32'd5, 16'd100, 31'd10);
    send_word(OP_ADD, 1'b1, 32'd5, 16'd90, 31'd10);
    send_word(OP_ADD, 1'b0, 32'd7, 16'd100, 31'd20);
    send_word(OP_ADD, 1'b1, 32'd3, 16'd90, 31'd25);
    send_word(OP_MATCH, 1'b0, '0, '0, '0);
    send_word(OP_CANCEL, 1'b0, 32'd7, '0, '0);
    send_word(OP_CANCEL, 1'b0, 32'd7, '0, '0);
    send_word(2'd3, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 31'h7FFF_FFFF);
    // extremes of id, price and quantity crossing each other
    send_word(OP_ADD, 1'b0, 32'd0, 16'hFFFF, 31'h7FFF_FFFF);
    send_word(OP_ADD, 1'b1, 32'hFFFF_FFFF, 16'd0, 31'h7FFF_FFFF);
    send_word(OP_MATCH, 1'b0, '0, '0, '0);
    // cancel from the middle, the tail, then the head of one FIFO
    send_word(OP_ADD, 1'b0, 32'd20, 16'd50, 31'd1);
    send_word(OP_ADD, 1'b0, 32'd21, 16'd50, 31'd2);
    send_word(OP_ADD, 1'b0, 32'd22, 16'd50, 31'd3);
    send_word(OP_CANCEL, 1'b0, 32'd21, '0, '0);
    send_word(OP_CANCEL, 1'b0, 32'd22, '0, '0);
    send_word(OP_CANCEL, 1'b0, 32'd20, '0, '0);
    send_word(OP_MATCH, 1'b0, '0, '0, '0);

    // Full book with the sender idling often.
    send_idle_pct = 59;
    fill_book();

    // Long receiver hold while words keep coming: the block backs up.
    send_idle_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++)
      add_order(1'($urandom_range(1)), 16'(100 + $urandom_range(0, 12)),
                31'($urandom_range(1, 30)));
    send_word(OP_MATCH, 1'b0, '0, '0, '0);
    // Pause the sender until every owed word is back.
    drain();

    // Random traffic across the idling phases.
    random_done = 0;
    while (random_done < NUM_RANDOM) begin
      case (random_done * 4 / NUM_RANDOM)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      random_burst(random_done);
    end

    drain();
    fails = sb.mismatches;
    if (sb.pending.size() != 0) begin
      $display("ERROR: %0d expected words never arrived", sb.pending.size());
      fails++;
    end
    $display("Covered %0d input words, %0d output words checked, %0d trades,", words_sent,
             sb.checked, sb.trades);
    $display("including full book, duplicate ids, FIFO cancels and long back-pressure.");
    if (fails == 0) begin
      $display("limit_order_book_matcher_top_tb: done, clean");
    end else begin
      $display("%0d mismatches", fails);
      $display("limit_order_book_matcher_top_tb: done, errors");
    end
    $finish;
  end

endmodule
